[sv/whcp_pkg.sv]
// whcp_pkg: types and constants shared by the wave header chunk parser
// no dependencies; imported by every module of the block

package whcp_pkg;

  localparam logic [31:0] TAG_RIFF      = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE      = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT       = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA      = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN_BYTES = 32'd16;
  localparam logic [31:0] POS_LIMIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] FIELD_BYTES   = 32'd4;
  localparam int unsigned FMT_NUM_BYTES = 16;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADFORM  = 3'd1;
  localparam logic [2:0] ST_FMTSHORT = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RIFF_ID   = 4'd1,
    PH_RIFF_SIZE = 4'd2,
    PH_RIFF_FORM = 4'd3,
    PH_TAG       = 4'd4,
    PH_SIZE      = 4'd5,
    PH_FMT_BODY  = 4'd6,
    PH_SKIP      = 4'd7,
    PH_DONE      = 4'd8
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } whcp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
    logic [31:0] data_offset;
  } whcp_out_t;

  // handshake between the parse stage and the result register
  typedef struct packed {
    logic res_vld;
    logic advance;
  } whcp_ctl_t;

endpackage

[sv/whcp_in_reg.sv]
// whcp_in_reg: input register holding one byte beat in front of the parser
// depends on whcp_pkg

module whcp_in_reg import whcp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  whcp_in_t in_data_i,
  input  logic     blocked_i,
  output logic     in_stall_o,
  output logic     item_vld_o,
  output whcp_in_t item_o
);

  logic     vld_q, vld_d;
  whcp_in_t item_q;
  logic     take;
  logic     drain;

  assign in_stall_o = vld_q && blocked_i;
  assign take       = in_valid_i && !in_stall_o;
  assign drain      = vld_q && !blocked_i;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (drain) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_data_i;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

[sv/whcp_parse.sv]
// whcp_parse: parse state machine, position and field counters, format capture
// depends on whcp_pkg; fed by whcp_in_reg, feeds whcp_out_reg

module whcp_parse import whcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      item_vld_i,
  input  whcp_in_t  item_i,
  input  logic      advance_i,
  output logic      res_vld_o,
  output whcp_out_t res_o
);

  phase_e      phase_q, phase_d, phase_e_w;
  logic [31:0] pos_q, pos_d, pos_e, pos_n;
  logic [31:0] shift_q, shift_d, shift_e, shift_n;
  logic [31:0] left_q, left_d, left_e, left_dec;
  logic [31:0] chunk_q, chunk_d, chunk_e;
  logic [31:0] tag_q, tag_d, tag_e;
  logic        seek_q, seek_d, seek_e;
  logic        locate_q;
  logic [7:0]  fmt_q [FMT_NUM_BYTES];
  logic [7:0]  fmt_d [FMT_NUM_BYTES];

  logic        first, last, cnt_done;
  logic [31:0] rest, skip_len;
  logic [32:0] skip_end;
  logic        skip_ovf;
  logic [3:0]  fmt_idx;
  logic        fmt_we;
  logic        fin;
  logic [2:0]  fin_st;
  logic [31:0] dsize, doff;

  assign first = item_i.first_byte;
  assign last  = item_i.last_byte;

  // a first byte restarts the file before the byte itself is parsed
  always_comb begin
    phase_e_w = first ? PH_RIFF_ID : phase_q;
    pos_e     = first ? '0 : pos_q;
    shift_e   = first ? '0 : shift_q;
    left_e    = first ? FIELD_BYTES : left_q;
    chunk_e   = first ? '0 : chunk_q;
    tag_e     = first ? '0 : tag_q;
    seek_e    = first ? 1'b0 : seek_q;
  end

  always_comb begin
    pos_n    = pos_e + 32'd1;
    shift_n  = {item_i.data_byte, shift_e[31:8]};
    left_dec = (left_e != '0) ? left_e - 32'd1 : '0;
    cnt_done = (left_dec == '0);
    rest     = chunk_e - FMT_MIN_BYTES;
    skip_len = (phase_e_w == PH_SIZE) ? shift_n : rest;
    skip_end = {1'b0, pos_n} + {1'b0, skip_len};
    skip_ovf = (skip_end >= {1'b0, POS_LIMIT});
    fmt_idx  = 4'd0 - left_e[3:0];
  end

  // next state
  always_comb begin
    phase_d = phase_e_w;
    left_d  = left_e;
    pos_d   = pos_e;
    shift_d = shift_e;
    chunk_d = chunk_e;
    tag_d   = tag_e;
    seek_d  = seek_e;
    fin     = 1'b0;
    fin_st  = ST_OK;
    dsize   = '0;
    doff    = '0;
    fmt_we  = 1'b0;
    if (item_vld_i && phase_e_w != PH_IDLE && phase_e_w != PH_DONE) begin
      if (pos_e == POS_LIMIT) begin
        fin    = 1'b1;
        fin_st = ST_OVERFLOW;
      end else begin
        pos_d   = pos_n;
        shift_d = shift_n;
        left_d  = left_dec;
        unique case (phase_e_w)
          PH_RIFF_ID, PH_TAG: begin
            if (cnt_done) begin
              tag_d   = shift_n;
              phase_d = (phase_e_w == PH_TAG) ? PH_SIZE : PH_RIFF_SIZE;
              left_d  = FIELD_BYTES;
            end
          end
          PH_RIFF_SIZE: begin
            if (cnt_done) begin
              phase_d = PH_RIFF_FORM;
              left_d  = FIELD_BYTES;
            end
          end
          PH_RIFF_FORM: begin
            if (cnt_done) begin
              if (tag_e != TAG_RIFF || shift_n != TAG_WAVE) begin
                fin    = 1'b1;
                fin_st = ST_BADFORM;
              end else begin
                phase_d = PH_TAG;
                left_d  = FIELD_BYTES;
              end
            end
          end
          PH_SIZE: begin
            if (cnt_done) begin
              chunk_d = shift_n;
              if (tag_e == (seek_e ? TAG_DATA : TAG_FMT)) begin
                if (pos_n == POS_LIMIT) begin
                  fin    = 1'b1;
                  fin_st = ST_OVERFLOW;
                end else if (seek_e) begin
                  fin   = 1'b1;
                  dsize = shift_n;
                  doff  = pos_n;
                end else if (shift_n < FMT_MIN_BYTES) begin
                  fin    = 1'b1;
                  fin_st = ST_FMTSHORT;
                end else begin
                  phase_d = PH_FMT_BODY;
                  left_d  = FMT_MIN_BYTES;
                end
              end else if (skip_ovf) begin
                fin    = 1'b1;
                fin_st = ST_OVERFLOW;
              end else if (shift_n == '0) begin
                phase_d = PH_TAG;
                left_d  = FIELD_BYTES;
              end else begin
                phase_d = PH_SKIP;
                left_d  = shift_n;
              end
            end
          end
          PH_FMT_BODY: begin
            fmt_we = 1'b1;
            if (cnt_done) begin
              if (skip_ovf) begin
                fin    = 1'b1;
                fin_st = ST_OVERFLOW;
              end else if (!locate_q) begin
                fin = 1'b1;
              end else begin
                seek_d = 1'b1;
                if (rest == '0) begin
                  phase_d = PH_TAG;
                  left_d  = FIELD_BYTES;
                end else begin
                  phase_d = PH_SKIP;
                  left_d  = rest;
                end
              end
            end
          end
          PH_SKIP: begin
            if (cnt_done) begin
              phase_d = PH_TAG;
              left_d  = FIELD_BYTES;
            end
          end
          default: ;
        endcase
      end
      // end of file with the parse still open
      if (!fin && last) begin
        fin    = 1'b1;
        fin_st = ST_SHORT;
      end
      if (fin) begin
        phase_d = PH_DONE;
        left_d  = '0;
      end
    end
  end

  // format bytes with the current byte forwarded for the final beat
  always_comb begin
    for (int i = 0; i < FMT_NUM_BYTES; i++) begin
      fmt_d[i] = fmt_q[i];
    end
    if (fmt_we) begin
      fmt_d[fmt_idx] = item_i.data_byte;
    end
  end

  // outputs
  always_comb begin
    res_vld_o = fin;
    res_o     = '0;
    res_o.status = fin_st;
    if (fin_st == ST_OK) begin
      res_o.format_tag      = {fmt_d[1], fmt_d[0]};
      res_o.channel_count   = {fmt_d[3], fmt_d[2]};
      res_o.sample_rate     = {fmt_d[7], fmt_d[6], fmt_d[5], fmt_d[4]};
      res_o.byte_rate       = {fmt_d[11], fmt_d[10], fmt_d[9], fmt_d[8]};
      res_o.block_align     = {fmt_d[13], fmt_d[12]};
      res_o.bits_per_sample = {fmt_d[15], fmt_d[14]};
      res_o.data_size       = dsize;
      res_o.data_offset     = doff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= '0;
      shift_q  <= '0;
      left_q   <= '0;
      chunk_q  <= '0;
      tag_q    <= '0;
      seek_q   <= 1'b0;
      locate_q <= 1'b1;
    end else begin
      if (advance_i) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        shift_q <= shift_d;
        left_q  <= left_d;
        chunk_q <= chunk_d;
        tag_q   <= tag_d;
        seek_q  <= seek_d;
      end
      if (cfg_we_i) begin
        locate_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && fmt_we) begin
      fmt_q[fmt_idx] <= item_i.data_byte;
    end
  end

endmodule

[sv/whcp_out_reg.sv]
// whcp_out_reg: result register between the parser and the output channel
// depends on whcp_pkg

module whcp_out_reg import whcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  whcp_ctl_t ctl_i,
  input  whcp_out_t res_i,
  input  logic      out_stall_i,
  output logic      blocked_o,
  output logic      out_valid_o,
  output whcp_out_t out_data_o
);

  logic      vld_q, vld_d;
  whcp_out_t data_q;
  logic      load;

  // a result beat can only enter when the register is free or draining
  assign blocked_o = ctl_i.res_vld && vld_q && out_stall_i;
  assign load      = ctl_i.res_vld && ctl_i.advance;

  always_comb begin
    vld_d = vld_q && out_stall_i;
    if (load) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

[sv/wave_header_chunk_parser_top.sv]
// wave_header_chunk_parser_top: RIFF/WAVE header parser, one file byte per beat
// depends on whcp_pkg, whcp_in_reg, whcp_parse, whcp_out_reg
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  whcp_in_t  (one file byte)
//   out      output     out_valid_o / out_stall_i whcp_out_t (one per file)
//   cfg      input      cfg_we_i                cfg_wdata_i (locate_data_chunk)
//
// one byte per cycle sustained unless a result waits on a stalled output; a byte's
// result passes the input register, single-pass parse logic and result register
// the parse stage holds only while a finished result waits on a stalled output
// reset clears the parse state, position and handshake registers and sets
// locate_data_chunk to 1; the format byte store is written before it is read

module wave_header_chunk_parser_top import whcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  whcp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output whcp_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic      item_vld;
  whcp_in_t  item;
  logic      blocked;
  logic      res_vld;
  whcp_ctl_t ctl;
  whcp_out_t res;

  assign ctl = '{res_vld: res_vld, advance: item_vld && !blocked};

  whcp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .blocked_i  (blocked),
    .in_stall_o (in_stall_o),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  whcp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_vld_i  (item_vld),
    .item_i      (item),
    .advance_i   (ctl.advance),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  whcp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .blocked_o   (blocked),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/whcp_checker.sv]
// whcp_checker: port-level checks on wave_header_chunk_parser_top
// depends on whcp_pkg; attached to the top level by the bind below

module whcp_checker import whcp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input whcp_out_t out_data_o
);

  // input only backs up behind a stalled result beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK || out_data_o.status == ST_BADFORM ||
                     out_data_o.status == ST_FMTSHORT || out_data_o.status == ST_SHORT ||
                     out_data_o.status == ST_OVERFLOW))
    else $error("result with unknown status code");

  // failed parses report nothing but the status
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |->
      (out_data_o.format_tag == '0 && out_data_o.sample_rate == '0 &&
       out_data_o.data_size == '0 && out_data_o.data_offset == '0))
    else $error("failure result carries field data");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result beat changed");

endmodule

bind wave_header_chunk_parser_top whcp_checker u_whcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[bench/tb_top.sv]
// tb_top: self-checking bench for wave_header_chunk_parser_top, fed whole WAV headers
// depends on whcp_pkg and the parser RTL; predicts each file's result and checks it
`timescale 1ns / 100ps

module tb_top;
  import whcp_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int CYCLE_LIMIT = 250000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  whcp_in_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  whcp_out_t out_beat;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  // idling and long receiver hold-off
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  int  hold_len = 0;
  bit  hold_toggle = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_cnt = 0;

  int  n_errors = 0;
  int  n_results = 0;
  int  n_files = 0;
  int  n_bytes = 0;
  int  n_cycles = 0;

  // parser shadow state
  bit          locate_data = 1'b1;
  phase_e      ph = PH_IDLE;
  logic [31:0] pos = '0;
  logic [31:0] shift_word = '0;
  logic [31:0] left = '0;
  logic [31:0] chunk_len = '0;
  logic [31:0] chunk_tag = '0;
  logic [63:0] fmt_words [2];
  bit          seeking_data = 1'b0;

  whcp_out_t   awaited_headers [$];
  logic [7:0]  file_bytes [$];

  wave_header_chunk_parser_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", n_cycles,
               awaited_headers.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall, or a long hold when a test asks for one
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_cnt = hold_len;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void close_file(logic [2:0] st, logic [31:0] dsize, logic [31:0] doff);
    whcp_out_t r;
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.format_tag      = fmt_words[0][15:0];
      r.channel_count   = fmt_words[0][31:16];
      r.sample_rate     = fmt_words[0][63:32];
      r.byte_rate       = fmt_words[1][31:0];
      r.block_align     = fmt_words[1][47:32];
      r.bits_per_sample = fmt_words[1][63:48];
      r.data_size       = dsize;
      r.data_offset     = doff;
    end
    awaited_headers.push_back(r);
    ph = PH_DONE;
    left = '0;
  endfunction

  function automatic bit start_skip(logic [31:0] len);
    if ({1'b0, pos} + {1'b0, len} >= {1'b0, POS_LIMIT}) return 1'b0;
    if (len == 0) begin
      ph = PH_TAG;
      left = FIELD_BYTES;
    end else begin
      ph = PH_SKIP;
      left = len;
    end
    return 1'b1;
  endfunction

  function automatic void parse_wave_byte(whcp_in_t it);
    logic [31:0] slot;
    logic [31:0] want;
    logic [31:0] rest;
    bit          fin;
    if (it.first_byte) begin
      pos = '0;
      shift_word = '0;
      chunk_len = '0;
      chunk_tag = '0;
      seeking_data = 1'b0;
      ph = PH_RIFF_ID;
      left = FIELD_BYTES;
    end
    if (ph == PH_IDLE || ph == PH_DONE) return;
    if (pos == POS_LIMIT) begin
      close_file(ST_OVERFLOW, '0, '0);
    end else begin
      pos++;
      shift_word = {it.data_byte, shift_word[31:8]};
      slot = FMT_MIN_BYTES - left;
      if (left != 0) left--;
      fin = (left == 0);
      case (ph)
        PH_RIFF_ID: if (fin) begin
          chunk_tag = shift_word;
          ph = PH_RIFF_SIZE;
          left = FIELD_BYTES;
        end
        PH_RIFF_SIZE: if (fin) begin
          ph = PH_RIFF_FORM;
          left = FIELD_BYTES;
        end
        PH_RIFF_FORM: if (fin) begin
          if (chunk_tag != TAG_RIFF || shift_word != TAG_WAVE) begin
            close_file(ST_BADFORM, '0, '0);
          end else begin
            ph = PH_TAG;
            left = FIELD_BYTES;
          end
        end
        PH_TAG: if (fin) begin
          chunk_tag = shift_word;
          ph = PH_SIZE;
          left = FIELD_BYTES;
        end
        PH_SIZE: if (fin) begin
          chunk_len = shift_word;
          want = seeking_data ? TAG_DATA : TAG_FMT;
          if (chunk_tag == want) begin
            if (pos == POS_LIMIT) close_file(ST_OVERFLOW, '0, '0);
            else if (seeking_data) close_file(ST_OK, chunk_len, pos);
            else if (chunk_len < FMT_MIN_BYTES) close_file(ST_FMTSHORT, '0, '0);
            else begin
              fmt_words[0] = '0;
              fmt_words[1] = '0;
              ph = PH_FMT_BODY;
              left = FMT_MIN_BYTES;
            end
          end else if (!start_skip(chunk_len)) begin
            close_file(ST_OVERFLOW, '0, '0);
          end
        end
        PH_FMT_BODY: begin
          fmt_words[slot[3]][{slot[2:0], 3'b000} +: 8] = it.data_byte;
          if (fin) begin
            rest = chunk_len - FMT_MIN_BYTES;
            if ({1'b0, pos} + {1'b0, rest} >= {1'b0, POS_LIMIT}) begin
              close_file(ST_OVERFLOW, '0, '0);
            end else if (!locate_data) begin
              close_file(ST_OK, '0, '0);
            end else begin
              seeking_data = 1'b1;
              void'(start_skip(rest));
            end
          end
        end
        PH_SKIP: if (fin) begin
          ph = PH_TAG;
          left = FIELD_BYTES;
        end
        default: ;
      endcase
    end
    if (ph != PH_DONE && it.last_byte) close_file(ST_SHORT, '0, '0);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    n_errors++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", n_results, name, got, want));
  endtask

  always @(posedge clk) begin
    whcp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_headers.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", out_beat.status));
      end else begin
        want = awaited_headers.pop_front();
        compare_field("status", out_beat.status, want.status);
        compare_field("format_tag", out_beat.format_tag, want.format_tag);
        compare_field("channel_count", out_beat.channel_count, want.channel_count);
        compare_field("sample_rate", out_beat.sample_rate, want.sample_rate);
        compare_field("byte_rate", out_beat.byte_rate, want.byte_rate);
        compare_field("block_align", out_beat.block_align, want.block_align);
        compare_field("bits_per_sample", out_beat.bits_per_sample, want.bits_per_sample);
        compare_field("data_size", out_beat.data_size, want.data_size);
        compare_field("data_offset", out_beat.data_offset, want.data_offset);
      end
      n_results++;
    end
  end

  // ---------------------------------------------------------------- driving

  // entered and left at a falling edge; valid stays up between back-to-back beats
  task automatic send_byte(whcp_in_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= it;
    do @(posedge clk); while (in_stall);
    parse_wave_byte(it);
    n_bytes++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_headers.size() != 0) @(negedge clk);
    // a file that ends without a result may still be in the pipe
    repeat (6) @(negedge clk);
  endtask

  task automatic write_locate(bit value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    locate_data = value;
  endtask

  task automatic send_file(bit with_last);
    whcp_in_t it;
    foreach (file_bytes[i]) begin
      it.data_byte  = file_bytes[i];
      it.first_byte = (i == 0);
      it.last_byte  = with_last && (i == file_bytes.size() - 1);
      send_byte(it);
    end
    file_bytes.delete();
    n_files++;
  endtask

  // bytes without first_byte: ignored unless a parse is still open
  task automatic send_noise(int count);
    whcp_in_t it;
    repeat (count) begin
      it.data_byte  = 8'($urandom);
      it.first_byte = 1'b0;
      it.last_byte  = ($urandom_range(3) == 0);
      send_byte(it);
    end
  endtask

  function automatic void put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void put_fill(int count, logic [7:0] value, bit rnd);
    repeat (count) file_bytes.push_back(rnd ? 8'($urandom) : value);
  endfunction

  function automatic void put_chunk(logic [31:0] tag, logic [31:0] size, int body);
    put_word(tag);
    put_word(size);
    put_fill(body, 8'h00, 1'b1);
  endfunction

  function automatic void put_header();
    put_word(TAG_RIFF);
    put_word($urandom);
    put_word(TAG_WAVE);
  endfunction

  function automatic void put_good_file();
    int extra;
    put_header();
    repeat ($urandom_range(2)) begin
      extra = $urandom_range(7);
      put_chunk($urandom, extra, extra);
    end
    extra = $urandom_range(6);
    put_chunk(TAG_FMT, FMT_MIN_BYTES + extra, FMT_NUM_BYTES + extra);
    if ($urandom_range(1)) begin
      extra = $urandom_range(5);
      put_chunk($urandom, extra, extra);
    end
    put_chunk(TAG_DATA, $urandom, $urandom_range(3));
  endfunction

  // mostly well-formed files with random content, the rest damaged
  task automatic make_random_file(output bit with_last);
    int kind;
    int idx;
    kind = $urandom_range(99);
    with_last = ($urandom_range(9) != 0);
    if (kind < 65) begin
      put_good_file();
    end else if (kind < 72) begin
      put_good_file();
      idx = $urandom_range(file_bytes.size() - 1);
      file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(7));
    end else if (kind < 80) begin
      put_good_file();
      idx = $urandom_range(file_bytes.size() - 1, 1);
      while (file_bytes.size() > idx) void'(file_bytes.pop_back());
    end else if (kind < 86) begin
      put_header();
      idx = $urandom_range(15);
      put_chunk(TAG_FMT, idx, idx);
    end else if (kind < 90) begin
      put_header();
      put_chunk($urandom, 32'hFFFF_FFF0 | $urandom_range(15), 0);
    end else if (kind < 94) begin
      put_header();
      put_chunk(TAG_FMT, 32'hFFFF_FFF0 | $urandom_range(15), FMT_NUM_BYTES);
    end else begin
      put_fill($urandom_range(20, 1), 8'h00, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_header_checks();
    send_noise(3);
    put_header();
    put_chunk(TAG_FMT, FMT_MIN_BYTES, 0);
    put_fill(FMT_NUM_BYTES, 8'hFF, 1'b0);
    put_chunk(TAG_DATA, 32'hFFFF_FFFF, 0);
    send_file(1'b1);
    put_word(TAG_RIFF ^ 32'h0100_0000);
    put_word($urandom);
    put_word(TAG_WAVE);
    send_file(1'b1);
    put_word(TAG_RIFF);
    put_word($urandom);
    put_word(TAG_WAVE ^ 32'h8000_0000);
    send_file(1'b1);
    put_header();
    void'(file_bytes.pop_back());
    send_file(1'b1);
    put_fill(1, 8'h52, 1'b0);
    send_file(1'b1);
  endtask

  task automatic test_format_chunk();
    put_header();
    put_chunk($urandom, 3, 3);
    put_chunk(TAG_FMT, FMT_MIN_BYTES - 1, 15);
    send_file(1'b1);
    put_header();
    put_chunk(TAG_FMT, 0, 0);
    send_file(1'b1);
    // data chunk seen before fmt is skipped like any other
    put_header();
    put_chunk(TAG_DATA, 2, 2);
    put_chunk($urandom, 0, 0);
    put_chunk(TAG_FMT, 19, 0);
    put_fill(19, 8'h00, 1'b0);
    put_chunk(TAG_DATA, 0, 1);
    send_file(1'b1);
    put_header();
    put_chunk(TAG_FMT, 20, 9);
    send_file(1'b1);
  endtask

  task automatic test_overflow();
    put_header();
    put_chunk($urandom, 32'hFFFF_FFFF, 0);
    send_file(1'b1);
    put_header();
    put_chunk(TAG_FMT, 32'hFFFF_FFFF, FMT_NUM_BYTES);
    send_file(1'b1);
  endtask

  task automatic test_restart();
    // a new file aborts the open one without a result
    put_header();
    put_chunk(TAG_FMT, FMT_MIN_BYTES, 6);
    send_file(1'b0);
    put_good_file();
    send_file(1'b1);
    // early end inside a skipped chunk, then stray bytes
    put_header();
    put_chunk($urandom, 10, 4);
    send_file(1'b1);
    send_noise(4);
  endtask

  task automatic test_locate_off();
    write_locate(1'b0);
    put_good_file();
    send_file(1'b1);
    put_header();
    put_chunk(TAG_FMT, 32'hFFFF_FFF8, FMT_NUM_BYTES);
    send_file(1'b1);
    write_locate(1'b1);
  endtask

  task automatic test_random_files(int snd_pct, int rcv_pct, int min_bytes, int min_files);
    int  start_bytes;
    int  start_files;
    bit  with_last;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start_bytes = n_bytes;
    start_files = n_files;
    while (n_bytes - start_bytes < min_bytes || n_files - start_files < min_files) begin
      if ($urandom_range(19) == 0) send_noise($urandom_range(4, 1));
      make_random_file(with_last);
      send_file(with_last);
      if ($urandom_range(24) == 0) wait_drained();
      if ($urandom_range(29) == 0) write_locate($urandom_range(1));
    end
  endtask

  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_len = 400;
    hold_toggle = ~hold_toggle;
    // every short bad header gives a result, so the block backs up
    repeat (8) begin
      put_word($urandom);
      put_word($urandom);
      put_word($urandom);
      send_file(1'b0);
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    snd_idle_pct = 20;
    rcv_idle_pct = 20;
    test_header_checks();
    test_format_chunk();
    test_overflow();
    test_restart();
    test_locate_off();
    test_backpressure();
    test_random_files(36, 58, 70, 2);
    write_locate(1'b0);
    test_random_files(58, 36, 70, 2);
    write_locate(1'b1);
    test_random_files(0, 0, 70, 2);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("%0d files in %0d byte beats, %0d results checked, %0d cycles", n_files, n_bytes,
             n_results, n_cycles);
    $display("covered bad magic, short fmt, early end, restart, overflow, locate on and off");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
